// ===== design/trqt_pkg.sv =====
// Package for the tile rotation block: command and status types, field codes.
// No dependencies; imported by the controller, the datapath and the top level.
package trqt_pkg;

  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned DIM_W = 5;
  localparam logic [DIM_W-1:0] TILE_DIM_RESET = 5'd16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] TURN_0 = 2'd0;
  localparam logic [1:0] TURN_1 = 2'd1;
  localparam logic [1:0] TURN_2 = 2'd2;
  localparam logic [1:0] TURN_3 = 2'd3;

  typedef struct packed {
    logic take;
    logic load_out;
  } trqt_cmd_t;

  typedef struct packed {
    logic is_read;
  } trqt_sts_t;

endpackage

// ===== design/trqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trqt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/trqt_ctrl.sv =====
// Controller for the tile rotation block: handshakes and the read sequence.
// Depends on trqt_pkg for the command and status types.
module trqt_ctrl
  import trqt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  trqt_sts_t sts,
  output trqt_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RDATA = 1'b1;

  logic st;
  logic st_next;

  assign in_ready = (st == ST_IDLE);
  assign cmd.take = in_valid && in_ready;
  assign cmd.load_out = (st == ST_RDATA) && (!out_valid || out_ready);

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (cmd.take && sts.is_read) begin
          st_next = ST_RDATA;
        end
      end
      ST_RDATA: begin
        if (cmd.load_out) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.is_read) |=> !in_ready)
    else $error("input taken while a read is in flight");

  a_write_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && !sts.is_read) |=> in_ready)
    else $error("write item stalled the input");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == ST_RDATA)
    else $error("result raised without a read");

endmodule

// ===== design/trqt_dpath.sv =====
// Datapath for the tile rotation block: side register, rotated address map,
// tile store and result register. Depends on trqt_pkg and trqt_ram.
module trqt_dpath
  import trqt_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [DIM_W-1:0] cfg_wr_data,
  input  logic             mode,
  input  logic [3:0]       row,
  input  logic [3:0]       col,
  input  logic [1:0]       quarter_turns,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  trqt_cmd_t        cmd,
  output trqt_sts_t        sts,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             coord_error
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned SW = (AW > DIM_W) ? AW : DIM_W;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADW = $clog2(DEPTH);
  localparam logic [6:0] MAX_SIDE = 7'(MAX_DIM);

  logic [DIM_W-1:0]   tile_dim;
  logic [6:0]         side_wide;
  logic [DIM_W-1:0]   side;
  logic               in_range;
  logic [1:0]         turns;
  logic [SW-1:0]      row_x;
  logic [SW-1:0]      col_x;
  logic [SW-1:0]      last;
  logic [SW-1:0]      sr;
  logic [SW-1:0]      sc;
  logic [ADW-1:0]     addr;
  logic [PIXEL_W-1:0] rdata;
  logic               err;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_dim <= TILE_DIM_RESET;
    end else if (cfg_wr_en) begin
      tile_dim <= cfg_wr_data;
    end
  end

  assign side_wide = ({2'b00, tile_dim} > MAX_SIDE) ? MAX_SIDE : {2'b00, tile_dim};
  assign side = side_wide[DIM_W-1:0];
  assign in_range = ({1'b0, row} < side) && ({1'b0, col} < side);

  assign row_x = {{(SW-4){1'b0}}, row};
  assign col_x = {{(SW-4){1'b0}}, col};
  assign last = SW'(side) - SW'(1);

  // write raw pixels unrotated
  assign turns = (mode == MODE_READ) ? quarter_turns : TURN_0;

  always_comb begin
    case (turns)
      TURN_0: begin
        sr = row_x;
        sc = col_x;
      end
      TURN_1: begin
        sr = last - col_x;
        sc = row_x;
      end
      TURN_2: begin
        sr = last - row_x;
        sc = last - col_x;
      end
      TURN_3: begin
        sr = col_x;
        sc = last - row_x;
      end
      default: begin
        sr = row_x;
        sc = col_x;
      end
    endcase
  end

  assign addr = ADW'(ADW'(sr[AW-1:0]) * ADW'(MAX_DIM) + ADW'(sc[AW-1:0]));

  assign sts.is_read = (mode == MODE_READ);

  trqt_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(DEPTH)
  ) u_tile_store (
    .clk  (clk),
    .we   (cmd.take && (mode == MODE_WRITE) && in_range),
    .waddr(addr),
    .wdata({in_red, in_green, in_blue}),
    .re   (cmd.take && (mode == MODE_READ)),
    .raddr(addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      err <= !in_range;
    end
    if (cmd.load_out) begin
      out_red <= err ? 8'd0 : rdata[23:16];
      out_green <= err ? 8'd0 : rdata[15:8];
      out_blue <= err ? 8'd0 : rdata[7:0];
      coord_error <= err;
    end
  end

endmodule

// ===== design/tile_rotate_quarter_turns_top.sv =====
// Top level of the tile rotation block: square RGB tile, rotated read-out.
// Depends on trqt_pkg, trqt_ctrl, trqt_dpath (and trqt_ram below it).
//
//   channel  handshake              payload
//   input    in_valid / in_ready    mode row col quarter_turns in_red in_green in_blue
//   output   out_valid / out_ready  out_red out_green out_blue coord_error
//   config   cfg_wr_en              cfg_wr_data (tile side)
//
// A write item leaves the input ready; the next item can enter in the following cycle.
// A read item holds the input while its data passes the registered read port of the tile store.
// rst is synchronous; it sets the tile side to 16 and leaves the store unwritten.
// A read whose result cannot leave (output still held) waits, and input stalls.
module tile_rotate_quarter_turns_top
  import trqt_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [3:0] row,
  input  logic [3:0] col,
  input  logic [1:0] quarter_turns,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       coord_error
);

  trqt_cmd_t cmd;
  trqt_sts_t sts;

  trqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  trqt_dpath #(
    .MAX_DIM(MAX_DIM)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mode         (mode),
    .row          (row),
    .col          (col),
    .quarter_turns(quarter_turns),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .cmd          (cmd),
    .sts          (sts),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .coord_error  (coord_error)
  );

endmodule
